### rtl/oal_pkg.sv
// Shared types and constants for the ordered array list.
`default_nettype none
package oal_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 6;

  // match scanner looks at this many cells per cycle
  localparam int SCAN_GROUP = 8;
  localparam int SCAN_SEL_W = 3;

  typedef enum logic [1:0] {
    CMD_INSERT       = 2'd0,
    CMD_DELETE       = 2'd1,
    CMD_SEARCH       = 2'd2,
    CMD_SEARCH_ALIAS = 2'd3   // high bit set: treated as search
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // broadcast control to every cell
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } cell_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_res_t;

endpackage
`default_nettype wire

### rtl/oal_cell.sv
// One list slot: holds an entry, shifts with its neighbors, compares for search.
`default_nettype none
module oal_cell #(
  parameter int CAPACITY = 32,
  parameter int IDX      = 0
) (
  input  wire logic                            clk,
  input  wire oal_pkg::cell_ctl_t              ctl,
  input  wire logic [$clog2(CAPACITY+1)-1:0]   count,
  input  wire logic [oal_pkg::WORD_W-1:0]      left,
  input  wire logic [oal_pkg::WORD_W-1:0]      right,
  output logic      [oal_pkg::WORD_W-1:0]      value,
  output logic                                 match
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (IW > oal_pkg::POS_W) ? IW + 1 : oal_pkg::POS_W + 1;

  logic [oal_pkg::WORD_W-1:0] val_r;
  logic [PW-1:0]              pos_m;
  logic [PW-1:0]              idx_m;
  logic                       below_cnt;

  assign pos_m     = PW'(ctl.pos);
  assign idx_m     = PW'(IDX);
  assign below_cnt = CW'(IDX) < count;

  always_ff @(posedge clk) begin
    if (ctl.ins && (idx_m > pos_m)) begin
      val_r <= left;
    end else if (ctl.ins && (idx_m == pos_m)) begin
      val_r <= ctl.word;
    end else if (ctl.del && (idx_m >= pos_m)) begin
      val_r <= right;
    end
  end

  assign value = val_r;
  // entries at or above the count are stale and never match
  assign match = below_cnt && (val_r == ctl.word);

endmodule
`default_nettype wire

### rtl/oal_scan.sv
// First-match scanner: walks the registered match vector a group per cycle.
`default_nettype none
module oal_scan #(
  parameter int CAPACITY = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [CAPACITY-1:0]             match,
  input  wire logic [$clog2(CAPACITY+1)-1:0]   count,
  output oal_pkg::scan_res_t                   res,
  output logic      [$clog2(CAPACITY)-1:0]     idx
);

  localparam int G  = oal_pkg::SCAN_GROUP;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int NG = (CAPACITY + G - 1) / G;
  localparam int VW = NG * G;
  localparam int BW = $clog2(VW + 1);
  localparam int SW = (BW > CW) ? BW + 1 : CW + 1;

  logic [VW-1:0]                 vec_r;
  logic [BW-1:0]                 base_r;
  logic                          busy_r;
  logic [oal_pkg::SCAN_SEL_W-1:0] enc;
  logic                          grp_hit;
  logic                          last_grp;
  logic [BW-1:0]                 idx_sum;

  always_comb begin
    enc = '0;
    for (int k = G - 1; k >= 0; k--) begin
      if (vec_r[k]) begin
        enc = oal_pkg::SCAN_SEL_W'(k);
      end
    end
  end

  assign grp_hit  = |vec_r[G-1:0];
  assign last_grp = (SW'(base_r) + SW'(G)) >= SW'(count);
  assign idx_sum  = base_r + BW'(enc);

  assign res.done = busy_r && (grp_hit || last_grp);
  assign res.hit  = busy_r && grp_hit;
  assign idx      = idx_sum[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (res.done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vec_r  <= VW'(match);
      base_r <= '0;
    end else if (busy_r) begin
      vec_r  <= vec_r >> G;
      base_r <= base_r + BW'(G);
    end
  end

endmodule
`default_nettype wire

### rtl/ordered_array_list.sv
// Ordered list of signed 32-bit words in a chain of cells, with insert, delete and search.
// Flow: insert/delete are checked and applied in S_EXEC; search starts the match scanner,
//   which walks groups of 8 cells in S_SCAN until a hit or past the count. A result waits
//   in S_HOLD while the output register cannot take it, then is loaded into that register.
// One command in flight; the next is taken once its result is registered, and the
//   output register buffers one result.
// Reset (rst_n low, synchronous): count and control clear; entries are not cleared.
`default_nettype none
module ordered_array_list #(
  parameter int CAPACITY = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [4:0] position, [36:5] word, [39:37] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] command
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // [4:0] found_position, [10:5] count, [15:11] zero
  output logic      [1:0]  out_tuser   // [1:0] status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int MW = (CW > oal_pkg::POS_W) ? CW : oal_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // latched command
  oal_pkg::cmd_t                      cmd_r;
  logic [oal_pkg::POS_W-1:0]          pos_r;
  logic signed [oal_pkg::WORD_W-1:0]  word_r;

  logic [CW-1:0] count_r, count_nxt;

  // result waiting for the output register
  oal_pkg::status_t          hold_st_r;
  logic [oal_pkg::POS_W-1:0] hold_fp_r;

  // output register
  logic                      out_valid_r;
  oal_pkg::status_t          out_st_r;
  logic [oal_pkg::POS_W-1:0] out_fp_r;
  logic [oal_pkg::CNT_W-1:0] out_cnt_r;

  // datapath control
  logic                      ins_go, del_go, scan_start;
  logic                      finish, ld_out, out_free;
  oal_pkg::status_t          fin_st;
  logic [oal_pkg::POS_W-1:0] fin_fp;
  logic [MW-1:0]             pos_m, cnt_m;
  logic                      is_full;

  oal_pkg::cell_ctl_t        cell_ctl;
  logic [oal_pkg::WORD_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]       cell_match;

  oal_pkg::scan_res_t        scan_res;
  logic [IW-1:0]             scan_idx;

  // ------------------------------------------------------------------
  // Handshake
  // ------------------------------------------------------------------
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= oal_pkg::cmd_t'(in_tuser);
      pos_r  <= in_tdata[4:0];
      word_r <= in_tdata[36:5];
    end
  end

  // ------------------------------------------------------------------
  // Control: range/full checks run on the latched command in S_EXEC
  // ------------------------------------------------------------------
  assign pos_m   = MW'(pos_r);
  assign cnt_m   = MW'(count_r);
  assign is_full = (count_r == CW'(CAPACITY));

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ins_go     = 1'b0;
    del_go     = 1'b0;
    scan_start = 1'b0;
    finish     = 1'b0;
    fin_st     = oal_pkg::ST_OK;
    fin_fp     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_r) inside
          oal_pkg::CMD_INSERT: begin
            finish = 1'b1;
            // range check comes before the full check
            if (pos_m > cnt_m) begin
              fin_st = oal_pkg::ST_RANGE;
            end else if (is_full) begin
              fin_st = oal_pkg::ST_FULL;
            end else begin
              ins_go    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end
          oal_pkg::CMD_DELETE: begin
            finish = 1'b1;
            if (pos_m >= cnt_m) begin
              fin_st = oal_pkg::ST_RANGE;
            end else begin
              del_go    = 1'b1;
              count_nxt = count_r - CW'(1);
            end
          end
          oal_pkg::CMD_SEARCH, oal_pkg::CMD_SEARCH_ALIAS: begin
            scan_start = 1'b1;
            state_nxt  = S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        if (scan_res.done) begin
          finish = 1'b1;
          if (scan_res.hit) begin
            fin_fp = oal_pkg::POS_W'(scan_idx);
          end else begin
            fin_st = oal_pkg::ST_MISS;
          end
        end
      end
      S_HOLD: begin
        fin_st = hold_st_r;
        fin_fp = hold_fp_r;
        finish = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (finish) begin
      state_nxt = out_free ? S_IDLE : S_HOLD;
    end
  end

  assign ld_out = finish && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && !out_free) begin
      hold_st_r <= fin_st;
      hold_fp_r <= fin_fp;
    end
  end

  // ------------------------------------------------------------------
  // Output register: lets the next command in while a result waits
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_st_r  <= fin_st;
      out_fp_r  <= fin_fp;
      out_cnt_r <= oal_pkg::CNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {5'b0, out_cnt_r, out_fp_r};

  // ------------------------------------------------------------------
  // Cell chain: insert shifts up from the left, delete pulls from the right
  // ------------------------------------------------------------------
  assign cell_ctl.ins  = ins_go;
  assign cell_ctl.del  = del_go;
  assign cell_ctl.pos  = pos_r;
  assign cell_ctl.word = word_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [oal_pkg::WORD_W-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = word_r;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    oal_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk   (clk),
      .ctl   (cell_ctl),
      .count (count_r),
      .left  (left_v),
      .right (right_v),
      .value (cell_val[i]),
      .match (cell_match[i])
    );
  end

  // ------------------------------------------------------------------
  // First-match scanner
  // ------------------------------------------------------------------
  oal_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .match (cell_match),
    .count (count_r),
    .res   (scan_res),
    .idx   (scan_idx)
  );

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> ($past(ins_go) || $past(del_go)))
    else $error("count changed without insert or delete");

  a_scan_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    scan_res.done |-> (state_r == S_SCAN))
    else $error("scanner finished outside search");

  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD) |-> out_valid_r)
    else $error("pending result while output register empty");

endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the ordered array list: insert, delete and search transactions.
module testbench;

  localparam int LIST_CAPACITY  = 32;
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transaction on either side
  localparam int MAX_SEND_GAP   = 20;

  typedef struct packed {
    oal_pkg::status_t status;
    logic [4:0]       found_pos;
    logic [5:0]       count;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = oal_pkg::CMD_INSERT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  // Predicted list contents and length
  logic [31:0]  list_words [LIST_CAPACITY];
  int           list_len = 0;
  list_result_t pending_results [$];

  int error_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  ordered_array_list #(
    .CAPACITY(LIST_CAPACITY)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one command to the predicted list and return the result it should give.
  function automatic list_result_t list_apply(oal_pkg::cmd_t c, logic [4:0] p,
                                              logic [31:0] w);
    list_result_t r;
    r.status    = oal_pkg::ST_OK;
    r.found_pos = '0;
    if (c[1]) begin
      // high command bit selects search, so the alias code searches too
      r.status = oal_pkg::ST_MISS;
      for (int i = list_len - 1; i >= 0; i--) begin
        if (list_words[i] == w) begin
          r.status    = oal_pkg::ST_OK;
          r.found_pos = 5'(i);
        end
      end
    end else if (c == oal_pkg::CMD_DELETE) begin
      if (int'(p) >= list_len) begin
        r.status = oal_pkg::ST_RANGE;
      end else begin
        for (int i = p; i < list_len - 1; i++) list_words[i] = list_words[i + 1];
        list_len--;
      end
    end else begin
      // range check wins over the full check
      if (int'(p) > list_len) begin
        r.status = oal_pkg::ST_RANGE;
      end else if (list_len >= LIST_CAPACITY) begin
        r.status = oal_pkg::ST_FULL;
      end else begin
        for (int i = list_len; i > p; i--) list_words[i] = list_words[i - 1];
        list_words[p] = w;
        list_len++;
      end
    end
    r.count = 6'(list_len);
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("error at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Drive one command transaction; the prediction is made when it is accepted.
  task automatic send_cmd(input oal_pkg::cmd_t c, input logic [4:0] p,
                          input logic [31:0] w);
    int gap;
    gap = 0;
    while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {3'b000, w, p};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(list_apply(c, p, w));
  endtask

  // Hold the input side until every outstanding result is back.
  task automatic wait_for_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mix of duplicates, extremes and fully random words.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(3))
      0: return 32'($urandom_range(3));
      1: begin
        case ($urandom_range(2))
          0: return 32'hffff_ffff;
          1: return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Result side: random backpressure.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result: status %0d pos %0d count %0d",
                               out_tuser, out_tdata[4:0], out_tdata[10:5]));
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status)
          report_error($sformatf("status %0d, expected %0d", out_tuser, want.status));
        if (out_tdata[4:0] !== want.found_pos)
          report_error($sformatf("found_position %0d, expected %0d",
                                 out_tdata[4:0], want.found_pos));
        if (out_tdata[10:5] !== want.count)
          report_error($sformatf("count %0d, expected %0d", out_tdata[10:5], want.count));
      end
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Empty list corner cases, extreme words, every command and the search alias.
  task automatic test_basic_ops();
    send_cmd(oal_pkg::CMD_DELETE, 5'd0, 32'h0);             // delete from empty
    send_cmd(oal_pkg::CMD_SEARCH, 5'd0, 32'h0);             // search on empty
    send_cmd(oal_pkg::CMD_SEARCH_ALIAS, 5'd31, 32'hffff_ffff);
    send_cmd(oal_pkg::CMD_INSERT, 5'd1, 32'h1234_5678);     // past the count
    send_cmd(oal_pkg::CMD_INSERT, 5'd31, 32'h0);
    send_cmd(oal_pkg::CMD_INSERT, 5'd0, 32'h8000_0000);
    send_cmd(oal_pkg::CMD_INSERT, 5'd1, 32'h7fff_ffff);     // append
    send_cmd(oal_pkg::CMD_INSERT, 5'd0, 32'hffff_ffff);     // front
    send_cmd(oal_pkg::CMD_INSERT, 5'd1, 32'h0000_0000);     // middle
    send_cmd(oal_pkg::CMD_INSERT, 5'd2, 32'hffff_ffff);     // duplicate word
    send_cmd(oal_pkg::CMD_SEARCH, 5'd17, 32'hffff_ffff);    // first of two matches
    send_cmd(oal_pkg::CMD_SEARCH, 5'd0, 32'h7fff_ffff);     // last entry
    send_cmd(oal_pkg::CMD_SEARCH_ALIAS, 5'd0, 32'h8000_0000);
    send_cmd(oal_pkg::CMD_SEARCH, 5'd0, 32'h0000_0005);     // miss on a non-empty list
    send_cmd(oal_pkg::CMD_DELETE, 5'd5, 32'h0);             // at the count
    send_cmd(oal_pkg::CMD_DELETE, 5'd31, 32'hffff_ffff);
    send_cmd(oal_pkg::CMD_DELETE, 5'd0, 32'h0);             // front
    send_cmd(oal_pkg::CMD_SEARCH, 5'd0, 32'hffff_ffff);     // match moved down
    send_cmd(oal_pkg::CMD_DELETE, 5'd3, 32'h0);             // last
    send_cmd(oal_pkg::CMD_DELETE, 5'd1, 32'h0);             // middle
  endtask

  // Fill to capacity, then probe the full list and its top entry.
  task automatic test_full_list();
    while (list_len < LIST_CAPACITY)
      send_cmd(oal_pkg::CMD_INSERT, 5'($urandom_range(list_len)), $urandom);
    send_cmd(oal_pkg::CMD_INSERT, 5'd0, 32'h0);
    send_cmd(oal_pkg::CMD_INSERT, 5'd31, 32'hffff_ffff);
    send_cmd(oal_pkg::CMD_SEARCH, 5'd0, list_words[LIST_CAPACITY - 1]);
    send_cmd(oal_pkg::CMD_DELETE, 5'd31, 32'h0);
    send_cmd(oal_pkg::CMD_INSERT, 5'd31, 32'h8000_0000);
    send_cmd(oal_pkg::CMD_SEARCH, 5'd0, 32'h8000_0000);
    send_cmd(oal_pkg::CMD_DELETE, 5'd0, 32'h0);
  endtask

  // Random commands in segments that lean toward growing or shrinking the list.
  task automatic test_random(input int n_items, input int s_pct, input int r_pct);
    int            grow;
    int            roll;
    oal_pkg::cmd_t c;
    logic [4:0]    p;
    logic [31:0]   w;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    grow = 1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) grow = $urandom_range(1);
      roll = $urandom_range(99);
      p = 5'($urandom);
      w = $urandom;
      if (roll < (grow ? 60 : 25)) begin
        c = oal_pkg::CMD_INSERT;
        if ($urandom_range(9) != 0)
          p = 5'($urandom_range(list_len < LIST_CAPACITY ? list_len : LIST_CAPACITY - 1));
        w = pick_word();
      end else if (roll < (grow ? 75 : 75)) begin
        c = oal_pkg::CMD_DELETE;
        if ($urandom_range(9) != 0 && list_len > 0) p = 5'($urandom_range(list_len - 1));
      end else begin
        c = ($urandom_range(7) == 0) ? oal_pkg::CMD_SEARCH_ALIAS : oal_pkg::CMD_SEARCH;
        if (list_len > 0 && $urandom_range(2) != 0)
          w = list_words[$urandom_range(list_len - 1)];
        else
          w = pick_word();
      end
      send_cmd(c, p, w);
    end
  endtask

  initial begin
    send_idle_pct = 36;
    recv_idle_pct = 76;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_full_list();
    wait_for_drain();
    test_random(270, 36, 76);
    wait_for_drain();
    test_random(270, 76, 36);
    wait_for_drain();
    test_random(270, 0, 0);

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
